### rtl/core/dsbt_pkg.sv
// Shared types and constants for the DHCP snooping binding table.
// Used by dsbt_cell, dsbt_ctrl and dhcp_snooping_binding_table_unit.
package dsbt_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int KIND_W  = 3;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int SEC_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_OUT_W = 7;

  localparam int IN_DATA_W  = IP_W + MAC_W + 3 * SEC_W;                     // 176
  localparam int OUT_RAW_W  = MAC_W + 2 * SEC_W + 2 * CNT_OUT_W;            // 126
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;                    // 128

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_LOOKUP = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_AGE    = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } fsm_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_PUSH,
    CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [SEC_W-1:0] lease;
    logic [SEC_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       keep;   // head word is written back during rotate
  } cell_ctl_t;

endpackage

### rtl/core/dsbt_cell.sv
// One slot of the binding chain: holds one entry, loads from a neighbor.
// Depends on dsbt_pkg.
module dsbt_cell #(
  parameter int             AW  = 6,
  parameter logic [AW-1:0]  IDX = '0
) (
  input  logic                clk,
  input  dsbt_pkg::cell_ctl_t ctl,
  input  logic [AW-1:0]       wr_ptr,
  input  dsbt_pkg::entry_t    prev_entry,
  input  dsbt_pkg::entry_t    next_entry,
  input  dsbt_pkg::entry_t    head_entry,
  output dsbt_pkg::entry_t    q
);

  dsbt_pkg::entry_t entry_r;
  dsbt_pkg::entry_t entry_nxt;

  always_comb begin
    case (ctl.mode)
      dsbt_pkg::CM_PUSH: begin
        entry_nxt = prev_entry;
      end
      dsbt_pkg::CM_ROTATE: begin
        // chain moves toward the head; a kept head word lands at the write slot
        entry_nxt = (ctl.keep && (wr_ptr == IDX)) ? head_entry : next_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

### rtl/core/dsbt_ctrl.sv
// Sequencer for the binding chain: op decode, rotate scan, result register.
// Depends on dsbt_pkg.
module dsbt_ctrl #(
  parameter int TABLE_DEPTH = dsbt_pkg::DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH),
  parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsbt_pkg::KIND_W-1:0]   in_kind,
  input  logic [dsbt_pkg::IP_W-1:0]     in_ip,
  input  logic [dsbt_pkg::SEC_W-1:0]    in_now,
  input  dsbt_pkg::entry_t              head_entry,
  output dsbt_pkg::cell_ctl_t           cell_ctl,
  output logic [AW-1:0]                 wr_ptr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsbt_pkg::STAT_W-1:0]   out_status,
  output logic [dsbt_pkg::MAC_W-1:0]    out_mac,
  output logic [dsbt_pkg::SEC_W-1:0]    out_lease,
  output logic [dsbt_pkg::SEC_W-1:0]    out_expiry,
  output logic [dsbt_pkg::CNT_OUT_W-1:0] out_removed,
  output logic [dsbt_pkg::CNT_OUT_W-1:0] out_occupancy,
  output logic [CW-1:0]                 count,
  output logic [CW-1:0]                 scan_left,
  output dsbt_pkg::fsm_t                state
);

  dsbt_pkg::fsm_t    state_r, state_nxt;
  dsbt_pkg::kind_t   kind_r, kind_nxt;
  logic [dsbt_pkg::IP_W-1:0]  key_r, key_nxt;
  logic [dsbt_pkg::SEC_W-1:0] now_r, now_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic [CW-1:0]     removed_r, removed_nxt;
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic              found_r, found_nxt;
  dsbt_pkg::status_t status_r, status_nxt;
  dsbt_pkg::entry_t  hit_r, hit_nxt;

  logic              ovalid_r, ovalid_nxt;
  dsbt_pkg::status_t ostat_r, ostat_nxt;
  dsbt_pkg::entry_t  ohit_r, ohit_nxt;
  logic [dsbt_pkg::CNT_OUT_W-1:0] orem_r, orem_nxt;
  logic [dsbt_pkg::CNT_OUT_W-1:0] oocc_r, oocc_nxt;

  logic accept;
  logic full;
  logic match;
  logic drop;
  logic out_free;
  logic resp_done;
  dsbt_pkg::kind_t in_kind_e;

  assign in_kind_e = dsbt_pkg::kind_t'(in_kind);
  assign accept    = in_valid && (state_r == dsbt_pkg::ST_IDLE);
  assign full      = (cnt_r == CW'(TABLE_DEPTH));
  assign match     = (head_entry.ip == key_r);
  assign out_free  = !ovalid_r || out_ready;
  assign resp_done = (state_r == dsbt_pkg::ST_RESP) && out_free;

  always_comb begin
    drop = 1'b0;
    case (kind_r)
      dsbt_pkg::KIND_AGE:    drop = (head_entry.expiry <= now_r);
      dsbt_pkg::KIND_DELETE: drop = match && !found_r;
      default:               drop = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_kind_e == dsbt_pkg::KIND_LOOKUP || in_kind_e == dsbt_pkg::KIND_DELETE ||
               in_kind_e == dsbt_pkg::KIND_AGE) && (cnt_r != '0)) begin
            state_nxt = dsbt_pkg::ST_SCAN;
          end else begin
            state_nxt = dsbt_pkg::ST_RESP;
          end
        end
      end
      dsbt_pkg::ST_SCAN: begin
        if (left_r == CW'(1)) begin
          state_nxt = dsbt_pkg::ST_RESP;
        end
      end
      dsbt_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = dsbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dsbt_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs toward the chain and the input side
  always_comb begin
    in_ready      = 1'b0;
    cell_ctl.mode = dsbt_pkg::CM_HOLD;
    cell_ctl.keep = 1'b0;
    case (state_r)
      dsbt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_kind_e == dsbt_pkg::KIND_INSERT && !full) begin
          cell_ctl.mode = dsbt_pkg::CM_PUSH;
        end
      end
      dsbt_pkg::ST_SCAN: begin
        cell_ctl.mode = dsbt_pkg::CM_ROTATE;
        cell_ctl.keep = !drop;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // op datapath
  always_comb begin
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    now_nxt     = now_r;
    cnt_nxt     = cnt_r;
    left_nxt    = left_r;
    removed_nxt = removed_r;
    wptr_nxt    = wptr_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    hit_nxt     = hit_r;
    if (accept) begin
      kind_nxt    = in_kind_e;
      key_nxt     = in_ip;
      now_nxt     = in_now;
      left_nxt    = cnt_r;
      removed_nxt = '0;
      wptr_nxt    = AW'(cnt_r - CW'(1));
      found_nxt   = 1'b0;
      status_nxt  = dsbt_pkg::STAT_OK;
      hit_nxt     = '0;
      case (in_kind_e)
        dsbt_pkg::KIND_INSERT: begin
          if (full) status_nxt = dsbt_pkg::STAT_FULL;
          else      cnt_nxt    = cnt_r + CW'(1);
        end
        dsbt_pkg::KIND_LOOKUP, dsbt_pkg::KIND_DELETE: begin
          if (cnt_r == '0) status_nxt = dsbt_pkg::STAT_NOT_FOUND;
        end
        dsbt_pkg::KIND_CLEAR: begin
          removed_nxt = cnt_r;
          cnt_nxt     = '0;
        end
        default: begin
          status_nxt = dsbt_pkg::STAT_OK;
        end
      endcase
    end else if (state_r == dsbt_pkg::ST_SCAN) begin
      left_nxt    = left_r - CW'(1);
      removed_nxt = removed_r + CW'(drop);
      wptr_nxt    = wptr_r - AW'(drop);
      if ((kind_r == dsbt_pkg::KIND_LOOKUP || kind_r == dsbt_pkg::KIND_DELETE) &&
          match && !found_r) begin
        found_nxt = 1'b1;
        if (kind_r == dsbt_pkg::KIND_LOOKUP) hit_nxt = head_entry;
      end
      if (left_r == CW'(1)) begin
        cnt_nxt = cnt_r - removed_nxt;
        if ((kind_r == dsbt_pkg::KIND_LOOKUP || kind_r == dsbt_pkg::KIND_DELETE) &&
            !found_nxt) begin
          status_nxt = dsbt_pkg::STAT_NOT_FOUND;
        end
      end
    end
  end

  // result register
  always_comb begin
    ovalid_nxt = ovalid_r;
    ostat_nxt  = ostat_r;
    ohit_nxt   = ohit_r;
    orem_nxt   = orem_r;
    oocc_nxt   = oocc_r;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    if (resp_done) begin
      ovalid_nxt = 1'b1;
      ostat_nxt  = status_r;
      ohit_nxt   = hit_r;
      orem_nxt   = dsbt_pkg::CNT_OUT_W'(removed_r);
      oocc_nxt   = dsbt_pkg::CNT_OUT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dsbt_pkg::ST_IDLE;
      cnt_r    <= '0;
      left_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    key_r     <= key_nxt;
    now_r     <= now_nxt;
    removed_r <= removed_nxt;
    wptr_r    <= wptr_nxt;
    found_r   <= found_nxt;
    status_r  <= status_nxt;
    hit_r     <= hit_nxt;
    ostat_r   <= ostat_nxt;
    ohit_r    <= ohit_nxt;
    orem_r    <= orem_nxt;
    oocc_r    <= oocc_nxt;
  end

  assign wr_ptr        = wptr_r;
  assign out_valid     = ovalid_r;
  assign out_status    = ostat_r;
  assign out_mac       = ohit_r.mac;
  assign out_lease     = ohit_r.lease;
  assign out_expiry    = ohit_r.expiry;
  assign out_removed   = orem_r;
  assign out_occupancy = oocc_r;
  assign count         = cnt_r;
  assign scan_left     = left_r;
  assign state         = state_r;

endmodule

### rtl/core/dhcp_snooping_binding_table_unit.sv
// DHCP snooping binding table, top level: chain of entry slots plus sequencer.
// Depends on dsbt_pkg, dsbt_cell and dsbt_ctrl.
//
// Holds up to TABLE_DEPTH bindings (IP, MAC, lease, expiry) newest first, one
// per slot in a chain of cells. One word in gives one result word out. Insert,
// clear, unused kinds and any op on an empty table go from accept straight to
// the response state and its result register. Lookup, delete and age tick
// first rotate the whole live chain once through the head slot, one entry per
// cycle; the head slot is where the key compare, expiry compare and drop
// decision happen, and a dropped entry is simply not written back, which
// compacts the chain. One word is worked on at a time; the result register
// lets the next word be accepted while a result waits on out_tready.
module dhcp_snooping_binding_table_unit #(
  parameter int TABLE_DEPTH = dsbt_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] client_ip, [79:32] client_mac, [111:80] lease_seconds,
  // [143:112] expiry_seconds, [175:144] now_seconds
  input  logic [dsbt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [2:0] kind
  input  logic [dsbt_pkg::KIND_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [47:0] hit_mac, [79:48] hit_lease, [111:80] hit_expiry,
  // [118:112] removed_count, [125:119] occupancy, [127:126] zero
  output logic [dsbt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [dsbt_pkg::STAT_W-1:0]       out_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  dsbt_pkg::entry_t    push_entry;
  dsbt_pkg::entry_t    slot_q [TABLE_DEPTH];
  dsbt_pkg::cell_ctl_t cell_ctl;
  logic [AW-1:0]       wr_ptr;
  logic [dsbt_pkg::STAT_W-1:0]    o_status;
  logic [dsbt_pkg::MAC_W-1:0]     o_mac;
  logic [dsbt_pkg::SEC_W-1:0]     o_lease;
  logic [dsbt_pkg::SEC_W-1:0]     o_expiry;
  logic [dsbt_pkg::CNT_OUT_W-1:0] o_removed;
  logic [dsbt_pkg::CNT_OUT_W-1:0] o_occ;
  logic [CW-1:0]       count;
  logic [CW-1:0]       scan_left;
  dsbt_pkg::fsm_t      state;

  assign push_entry.ip     = in_tdata[31:0];
  assign push_entry.mac    = in_tdata[79:32];
  assign push_entry.lease  = in_tdata[111:80];
  assign push_entry.expiry = in_tdata[143:112];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
    dsbt_pkg::entry_t prev_e;
    dsbt_pkg::entry_t next_e;
    if (i == 0) begin : g_first
      assign prev_e = push_entry;
    end else begin : g_mid_p
      assign prev_e = slot_q[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_e = slot_q[i];
    end else begin : g_mid_n
      assign next_e = slot_q[i+1];
    end
    dsbt_cell #(
      .AW  (AW),
      .IDX (AW'(i))
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .wr_ptr     (wr_ptr),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .head_entry (slot_q[0]),
      .q          (slot_q[i])
    );
  end

  dsbt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_kind       (in_tuser),
    .in_ip         (in_tdata[31:0]),
    .in_now        (in_tdata[175:144]),
    .head_entry    (slot_q[0]),
    .cell_ctl      (cell_ctl),
    .wr_ptr        (wr_ptr),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_status    (o_status),
    .out_mac       (o_mac),
    .out_lease     (o_lease),
    .out_expiry    (o_expiry),
    .out_removed   (o_removed),
    .out_occupancy (o_occ),
    .count         (count),
    .scan_left     (scan_left),
    .state         (state)
  );

  assign out_tuser = o_status;
  assign out_tdata = {2'b00, o_occ, o_removed, o_expiry, o_lease, o_mac};

  // occupancy never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // a scan never runs with nothing left to rotate
  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state == dsbt_pkg::ST_SCAN) |-> (scan_left != '0) && (scan_left <= count))
    else $error("scan counter out of range");

  // no new word is taken while an op is still in flight
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("word accepted while previous op busy");

endmodule
